FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL files of the pulse record and replay block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: rtl/core/irpr_pkg.sv
// Package: types, codes and constants of the pulse record and replay block.
`default_nettype none

package irpr_pkg;

	localparam int DEF_TABLE_DEPTH = 64;

	localparam int FUNC_W = 3;
	localparam int IDX_W  = 6;
	localparam int VAL_W  = 8;
	// wide enough to hold a table depth up to 511 as a value
	localparam int CMP_W  = 9;

	localparam logic [VAL_W-1:0] END_MARK = 8'hFF;
	localparam logic [VAL_W-1:0] ZERO_VAL = 8'h00;

	localparam logic [FUNC_W-1:0] FN_TICK      = 3'd0;
	localparam logic [FUNC_W-1:0] FN_EDGE      = 3'd1;
	localparam logic [FUNC_W-1:0] FN_START_REC = 3'd2;
	localparam logic [FUNC_W-1:0] FN_START_REP = 3'd3;
	localparam logic [FUNC_W-1:0] FN_WRITE     = 3'd4;
	localparam logic [FUNC_W-1:0] FN_READ      = 3'd5;
	localparam logic [FUNC_W-1:0] FN_ABORT     = 3'd6;

	// table write request; clr wipes every entry before the write lands
	typedef struct packed {
		logic             we;
		logic             clr;
		logic [VAL_W-1:0] data;
	} irpr_wr_t;

	typedef struct packed {
		logic             ir_level;
		logic             is_recording;
		logic             is_replaying;
		logic [IDX_W-1:0] position;
		logic [VAL_W-1:0] read_value;
	} irpr_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/ir_pulse_record_replay_top.sv
// A transaction accepted into the input register has its result in the output
// register. Throughput: one transaction per cycle unless the output stalls, set
// by both registers and the single-pass update, with table reads prefetched.
// Reset: asynchronous, clears the table (valid bits), cursor, counters and
// flags; level idles high. No clearing pass, the block is ready at once.
`default_nettype none

module ir_pulse_record_replay_top
	import irpr_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // entry_index[5:0], entry_value[13:6]
	input  wire logic [2:0]  s_axis_tuser,  // func[2:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [23:0] m_axis_tdata   // ir_level[0], is_recording[1],
	                                        // is_replaying[2], position[8:3],
	                                        // read_value[16:9]
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic              vld_s1;
	logic [FUNC_W-1:0] func_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [VAL_W-1:0]  val_s1;

	logic              out_v_q;
	irpr_res_t         out_q;

	logic              step;
	logic              in_fire;
	logic [CMP_W-1:0]  in_idx_ext;

	irpr_wr_t          wr;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     nxt_addr;
	logic [VAL_W-1:0]  nxt_val;
	logic [VAL_W-1:0]  rd_val;
	irpr_res_t         res;

	assign step          = vld_s1 && (!out_v_q || m_axis_tready);
	assign s_axis_tready = !vld_s1 || step;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign in_idx_ext    = CMP_W'(s_axis_tdata[IDX_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_fire) begin
			vld_s1 <= 1'b1;
		end else if (step) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_s1 <= s_axis_tuser[FUNC_W-1:0];
			idx_s1  <= s_axis_tdata[IDX_W-1:0];
			val_s1  <= s_axis_tdata[IDX_W+VAL_W-1:IDX_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (step) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= res;
		end
	end

	irpr_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.wr_addr (wr_addr),
		.ra_en   (step),
		.ra_addr (nxt_addr),
		.ra_data (nxt_val),
		.rb_en   (in_fire),
		.rb_addr (in_idx_ext[AW-1:0]),
		.rb_data (rd_val)
	);

	irpr_core #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.func_s1  (func_s1),
		.idx_s1   (idx_s1),
		.val_s1   (val_s1),
		.nxt_val  (nxt_val),
		.rd_val   (rd_val),
		.wr       (wr),
		.wr_addr  (wr_addr),
		.nxt_addr (nxt_addr),
		.res      (res)
	);

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {7'd0, out_q.read_value, out_q.position, out_q.is_replaying,
		out_q.is_recording, out_q.ir_level};

endmodule

`default_nettype wire

FILE: rtl/core/irpr_table.sv
// Pulse table: one write port, two registered read ports, per-entry valid bits.
`default_nettype none

module irpr_table
	import irpr_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire irpr_wr_t         wr,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic             ra_en,
	input  wire logic [AW-1:0]    ra_addr,
	output logic      [VAL_W-1:0] ra_data,
	input  wire logic             rb_en,
	input  wire logic [AW-1:0]    rb_addr,
	output logic      [VAL_W-1:0] rb_data
);

	logic [VAL_W-1:0]       mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;

	logic [VAL_W-1:0] ra_raw_q, rb_raw_q;
	logic             ra_vld_q, rb_vld_q;
	logic             ra_byp_q, rb_byp_q;
	logic [VAL_W-1:0] ra_bval_q, rb_bval_q;

	logic             ra_hit, rb_hit;

	// a write landing on the address being read overrides the stale array data
	assign ra_hit = wr.we && (wr_addr == ra_addr);
	assign rb_hit = wr.we && (wr_addr == rb_addr);

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr_addr] <= wr.data;
		end
		if (ra_en) begin
			ra_raw_q <= mem[ra_addr];
		end
		if (rb_en) begin
			rb_raw_q <= mem[rb_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			ra_vld_q  <= 1'b0;
			rb_vld_q  <= 1'b0;
			ra_byp_q  <= 1'b0;
			rb_byp_q  <= 1'b0;
			ra_bval_q <= ZERO_VAL;
			rb_bval_q <= ZERO_VAL;
		end else begin
			if (wr.clr) begin
				valid_q <= '0;
			end
			if (wr.we) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ra_en) begin
				ra_vld_q  <= valid_q[ra_addr];
				ra_byp_q  <= wr.clr || ra_hit;
				ra_bval_q <= ra_hit ? wr.data : ZERO_VAL;
			end
			if (rb_en) begin
				rb_vld_q  <= valid_q[rb_addr];
				rb_byp_q  <= wr.clr || rb_hit;
				rb_bval_q <= rb_hit ? wr.data : ZERO_VAL;
			end
		end
	end

	assign ra_data = ra_byp_q ? ra_bval_q : (ra_vld_q ? ra_raw_q : ZERO_VAL);
	assign rb_data = rb_byp_q ? rb_bval_q : (rb_vld_q ? rb_raw_q : ZERO_VAL);

endmodule

`default_nettype wire

FILE: rtl/core/irpr_core.sv
// Record and replay control: state registers and the per-transaction update.
`default_nettype none
`include "assert_macros.svh"

module irpr_core
	import irpr_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [FUNC_W-1:0] func_s1,
	input  wire logic [IDX_W-1:0]  idx_s1,
	input  wire logic [VAL_W-1:0]  val_s1,
	input  wire logic [VAL_W-1:0]  nxt_val,
	input  wire logic [VAL_W-1:0]  rd_val,
	output irpr_wr_t               wr,
	output logic      [AW-1:0]     wr_addr,
	output logic      [AW-1:0]     nxt_addr,
	output irpr_res_t              res
);

	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
	localparam logic [AW-1:0] FIRST_IDX = '0;

	logic [AW-1:0]    cursor_q, cursor_d;
	logic [VAL_W-1:0] countdown_q, countdown_d;
	logic             recording_q, recording_d;
	logic             armed_q, armed_d;
	logic             replaying_q, replaying_d;
	logic             level_q, level_d;
	// cur_q mirrors table[cursor], e0_q mirrors table[0]
	logic [VAL_W-1:0] cur_q, cur_d;
	logic [VAL_W-1:0] e0_q, e0_d;

	irpr_wr_t         wr_c;
	logic [AW-1:0]    waddr_c;
	logic [VAL_W-1:0] rd_c;
	logic [VAL_W-1:0] cur_base;
	logic             restart;
	logic             in_range;
	logic [CMP_W-1:0] idx_ext;
	logic [CMP_W-1:0] pos_ext;
	logic             at_last;

	assign idx_ext  = CMP_W'(idx_s1);
	assign in_range = idx_ext < CMP_W'(TABLE_DEPTH);
	assign at_last  = cursor_q == LAST_IDX;

	always_comb begin
		cursor_d    = cursor_q;
		countdown_d = countdown_q;
		recording_d = recording_q;
		armed_d     = armed_q;
		replaying_d = replaying_q;
		level_d     = level_q;
		wr_c        = '{we: 1'b0, clr: 1'b0, data: ZERO_VAL};
		waddr_c     = cursor_q;
		rd_c        = ZERO_VAL;
		restart     = 1'b0;
		case (func_s1)
			FN_TICK: begin
				if (recording_q) begin
					if (armed_q) begin
						if (cur_q == END_MARK) begin
							recording_d = 1'b0;
						end else begin
							wr_c.we   = 1'b1;
							wr_c.data = cur_q + 8'd1;
						end
					end
				end else if (replaying_q) begin
					if (countdown_q > 8'd1) begin
						countdown_d = countdown_q - 8'd1;
					end else begin
						level_d = !level_q;
						if (at_last) begin
							replaying_d = 1'b0;
							countdown_d = ZERO_VAL;
							level_d     = 1'b1;
						end else begin
							cursor_d = cursor_q + AW'(1);
							if (nxt_val == ZERO_VAL || nxt_val == END_MARK) begin
								replaying_d = 1'b0;
								countdown_d = ZERO_VAL;
								level_d     = 1'b1;
							end else begin
								countdown_d = nxt_val;
							end
						end
					end
				end
			end
			FN_EDGE: begin
				if (recording_q) begin
					if (!armed_q) begin
						armed_d = 1'b1;
					end else if (at_last) begin
						recording_d = 1'b0;
					end else begin
						cursor_d = cursor_q + AW'(1);
						if (nxt_val == END_MARK) begin
							recording_d = 1'b0;
						end
					end
				end
			end
			FN_START_REC: begin
				wr_c        = '{we: 1'b1, clr: 1'b1, data: END_MARK};
				waddr_c     = LAST_IDX;
				restart     = 1'b1;
				cursor_d    = FIRST_IDX;
				replaying_d = 1'b0;
				countdown_d = ZERO_VAL;
				level_d     = 1'b1;
				recording_d = 1'b1;
				armed_d     = 1'b0;
			end
			FN_START_REP: begin
				restart     = 1'b1;
				recording_d = 1'b0;
				armed_d     = 1'b0;
				cursor_d    = FIRST_IDX;
				if (e0_q == ZERO_VAL || e0_q == END_MARK) begin
					replaying_d = 1'b0;
					countdown_d = ZERO_VAL;
					level_d     = 1'b1;
				end else begin
					countdown_d = e0_q;
					replaying_d = 1'b1;
					level_d     = 1'b0;
				end
			end
			FN_WRITE: begin
				if (in_range) begin
					wr_c.we   = 1'b1;
					wr_c.data = val_s1;
					waddr_c   = idx_ext[AW-1:0];
				end
			end
			FN_READ: begin
				if (in_range) begin
					rd_c = rd_val;
				end
			end
			FN_ABORT: begin
				recording_d = 1'b0;
				armed_d     = 1'b0;
				replaying_d = 1'b0;
				countdown_d = ZERO_VAL;
				level_d     = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// track the table contents at the new cursor and at entry 0 after this write
	always_comb begin
		if (restart) begin
			cur_base = e0_q;
		end else if (cursor_d != cursor_q) begin
			cur_base = nxt_val;
		end else begin
			cur_base = cur_q;
		end

		if (wr_c.clr) begin
			cur_d = (waddr_c == cursor_d) ? wr_c.data : ZERO_VAL;
			e0_d  = (waddr_c == FIRST_IDX) ? wr_c.data : ZERO_VAL;
		end else begin
			cur_d = (wr_c.we && waddr_c == cursor_d) ? wr_c.data : cur_base;
			e0_d  = (wr_c.we && waddr_c == FIRST_IDX) ? wr_c.data : e0_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= FIRST_IDX;
			countdown_q <= ZERO_VAL;
			recording_q <= 1'b0;
			armed_q     <= 1'b0;
			replaying_q <= 1'b0;
			level_q     <= 1'b1;
			cur_q       <= ZERO_VAL;
			e0_q        <= ZERO_VAL;
		end else if (step) begin
			cursor_q    <= cursor_d;
			countdown_q <= countdown_d;
			recording_q <= recording_d;
			armed_q     <= armed_d;
			replaying_q <= replaying_d;
			level_q     <= level_d;
			cur_q       <= cur_d;
			e0_q        <= e0_d;
		end
	end

	assign wr.we    = wr_c.we && step;
	assign wr.clr   = wr_c.clr && step;
	assign wr.data  = wr_c.data;
	assign wr_addr  = waddr_c;
	// prefetch the entry after the new cursor; wraps harmlessly at the last entry
	assign nxt_addr = cursor_d + AW'(1);

	assign pos_ext          = CMP_W'(cursor_d);
	assign res.ir_level     = level_d;
	assign res.is_recording = recording_d;
	assign res.is_replaying = replaying_d;
	assign res.position     = pos_ext[IDX_W-1:0];
	assign res.read_value   = rd_c;

	`ASSERT_NEVER(a_rec_rep_excl, clk, arst_n, recording_q && replaying_q)
	`ASSERT_CLK(a_rep_count_live, clk, arst_n, replaying_q |-> countdown_q != ZERO_VAL)
	`ASSERT_CLK(a_idle_level_high, clk, arst_n, !replaying_q |-> level_q)
	`ASSERT_CLK(a_clear_restarts, clk, arst_n,
		wr.clr |=> (cursor_q == FIRST_IDX) && recording_q && !armed_q)

endmodule

`default_nettype wire
